>>> rtl/aps_pkg.sv
package aps_pkg;

  localparam int CMD_W      = 3;
  localparam int ARITY_W    = 3;
  localparam int OBJ_W      = 4;
  localparam int POS_W      = 2;
  localparam int CODE_W     = 5;
  localparam int OFS_W      = 7;
  localparam int SLOT_W     = 8;   // offset + code
  localparam int RANK_W     = 15;  // slot * N + slot
  localparam int OUT_RANK_W = 13;
  localparam int ARG_FIELDS = 4;
  localparam int NUM_POS    = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;
  localparam int ROW_BITS   = 64;  // bitmap row width
  localparam int ROW_SEL_W  = 6;

  localparam logic [CMD_W-1:0] CMD_LOAD    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_QVERTEX = 3'd2;
  localparam logic [CMD_W-1:0] CMD_QEDGE   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_OFFSET0    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET3    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT = 3'd4;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [ARITY_W-1:0] arity;
    logic [OBJ_W-1:0]   arg_obj0;
    logic [OBJ_W-1:0]   arg_obj1;
    logic [OBJ_W-1:0]   arg_obj2;
    logic [OBJ_W-1:0]   arg_obj3;
    logic [POS_W-1:0]   first_pos;
    logic [OBJ_W-1:0]   first_obj;
    logic [POS_W-1:0]   second_pos;
    logic [OBJ_W-1:0]   second_obj;
    logic [CODE_W-1:0]  domain_code;
  } req_t;

  typedef struct packed {
    logic                  hit;
    logic [OUT_RANK_W-1:0] slot_rank;
  } rsp_t;

endpackage

>>> rtl/aps_stream_if.sv
interface aps_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/aps_ram.sv
module aps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/aps_rank_unit.sv
module aps_rank_unit #(
  parameter int SET_BITS = 8192
) (
  input  logic [aps_pkg::SLOT_W-1:0] slot_a,
  input  logic [aps_pkg::SLOT_W-1:0] slot_b,
  input  logic                       is_edge,
  input  logic [aps_pkg::OFS_W-1:0]  slot_count,
  output logic [aps_pkg::RANK_W-1:0] rank,
  output logic                       in_range
);
  import aps_pkg::*;

  logic [SLOT_W+OFS_W-1:0] prod;

  // vertex: rank = slot_b (slot_a == slot_b); edge: slot_a * N + slot_b
  always_comb begin
    prod     = slot_a * slot_count;
    rank     = (is_edge ? RANK_W'(prod) : '0) + RANK_W'(slot_b);
    in_range = (32'(rank) < 32'(SET_BITS));
  end

endmodule

>>> rtl/assignment_pair_bitset.sv
// Membership bitmap over hashed vertex / edge assignments.
// req (sink): one command per beat (load code, insert atom, query vertex,
//   query edge, clear). rsp (source): exactly one beat per command, with
//   hit and slot_rank; both are zero for anything but a query.
// cfg_wr_en/cfg_index/cfg_data write the four position offsets and the
//   slot count N; write them only while the block is idle.
// Commands share one code-table RAM, one rank multiplier and one read
//   and one write port on the bitmap. Load, unused codes and insert of
//   arity 0 go straight to the result; a query looks up its codes, forms
//   one rank and reads its row; an insert of arity r >= 1 marks r + r*(r-1)/2
//   ranks; clear sweeps the bitmap only, not the code table.
// Each bitmap bit costs a read and a write of its 64-bit row.
// After reset the block sweeps the code table and the bitmap to zero
//   with req.ready low; config writes are taken meanwhile.
// The result sits in an output register: a new command is accepted while
//   it waits, but the next result holds until rsp is taken.
module assignment_pair_bitset #(
  parameter int MAX_ARITY   = 4,
  parameter int MAX_OBJECTS = 16,
  parameter int SET_BITS    = 8192
) (
  input  logic                            clk,
  input  logic                            rst,
  aps_stream_if.sink                      req,
  aps_stream_if.source                    rsp,
  input  logic                            cfg_wr_en,
  input  logic [aps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [aps_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import aps_pkg::*;

  localparam int TBL_DEPTH = MAX_ARITY * MAX_OBJECTS;
  localparam int TBL_AW    = $clog2(TBL_DEPTH);
  localparam int ROWS      = (SET_BITS + ROW_BITS - 1) / ROW_BITS;
  localparam int ROW_AW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int SWEEP_LEN = (TBL_DEPTH > ROWS) ? TBL_DEPTH : ROWS;
  localparam int SWEEP_W   = $clog2(SWEEP_LEN);
  localparam int ARITY_CAP = (MAX_ARITY < ARG_FIELDS) ? MAX_ARITY : ARG_FIELDS;

  typedef enum logic [5:0] {
    ST_SWEEP  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_LOOK   = 6'b000100,
    ST_RANK   = 6'b001000,
    ST_WRITE  = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  state_t state;

  logic [OFS_W-1:0]   offset [NUM_POS];
  logic [OFS_W-1:0]   slot_count;

  logic [POS_W-1:0]   lpos  [NUM_POS];
  logic [OBJ_W-1:0]   lobj  [NUM_POS];
  logic [SLOT_W-1:0]  slots [NUM_POS];
  logic [ARITY_W-1:0] n;
  logic [ARITY_W-1:0] k;
  logic [ARITY_W-1:0] km1;
  logic [POS_W-1:0]   prev_pos;
  logic               prev_ok;
  logic [1:0]         a;
  logic [1:0]         b;
  logic               is_query;
  logic [SWEEP_W-1:0] sweep_cnt;
  logic               sweep_table;
  logic               sweep_reply;
  logic [RANK_W-1:0]  rank_r;
  logic               inr_r;
  logic               res_hit;
  logic [OUT_RANK_W-1:0] res_rank;
  logic               rsp_valid;
  rsp_t               rsp_data;

  logic               accept;
  logic               req_query;
  logic [ARITY_W-1:0] arity_eff;
  logic [ARITY_W-1:0] b_inc;
  logic [ARITY_W-1:0] a_inc;

  logic               tbl_wr_en;
  logic [TBL_AW-1:0]  tbl_wr_addr;
  logic [CODE_W-1:0]  tbl_wr_data;
  logic               tbl_rd_en;
  logic [TBL_AW-1:0]  tbl_rd_addr;
  logic [CODE_W-1:0]  tbl_rd_data;
  logic               look_ok;

  logic               bm_wr_en;
  logic [ROW_AW-1:0]  bm_wr_addr;
  logic [ROW_BITS-1:0] bm_wr_data;
  logic               bm_rd_en;
  logic [ROW_AW-1:0]  bm_rd_addr;
  logic [ROW_BITS-1:0] bm_rd_data;

  logic [RANK_W-1:0]  rank;
  logic               in_range;
  logic [31:0]        rank_ext;
  logic [31:0]        rank_r_ext;
  logic [31:0]        sweep_ext;
  logic [31:0]        tbl_idx;

  function automatic logic [31:0] table_index(input logic [POS_W-1:0] pos,
                                              input logic [OBJ_W-1:0] obj);
    return 32'(pos) * 32'(MAX_OBJECTS) + 32'(obj);
  endfunction

  function automatic logic table_hit(input logic [POS_W-1:0] pos,
                                     input logic [OBJ_W-1:0] obj);
    return (32'(pos) < 32'(MAX_ARITY)) && (32'(obj) < 32'(MAX_OBJECTS));
  endfunction

  assign accept      = req.valid && req.ready;
  assign req.ready   = (state == ST_IDLE);
  assign rsp.valid   = rsp_valid;
  assign rsp.payload = rsp_data;

  assign req_query = (req.payload.cmd == CMD_QVERTEX) || (req.payload.cmd == CMD_QEDGE);
  assign arity_eff = (req.payload.arity > ARITY_W'(ARITY_CAP)) ?
                     ARITY_W'(ARITY_CAP) : req.payload.arity;
  assign km1   = k - 3'd1;
  assign b_inc = {1'b0, b} + 3'd1;
  assign a_inc = {1'b0, a} + 3'd1;

  assign rank_ext   = 32'(rank);
  assign rank_r_ext = 32'(rank_r);
  assign sweep_ext  = 32'(sweep_cnt);

  // code table port: sweep or load write, lookup read
  always_comb begin
    tbl_idx     = '0;
    tbl_wr_en   = 1'b0;
    tbl_wr_addr = '0;
    tbl_wr_data = '0;
    tbl_rd_en   = 1'b0;
    tbl_rd_addr = '0;
    look_ok     = 1'b0;
    if (state == ST_SWEEP) begin
      tbl_wr_en   = sweep_table && (sweep_ext < 32'(TBL_DEPTH));
      tbl_wr_addr = sweep_ext[TBL_AW-1:0];
    end else if (accept && req.payload.cmd == CMD_LOAD) begin
      tbl_idx     = table_index(req.payload.first_pos, req.payload.first_obj);
      tbl_wr_en   = table_hit(req.payload.first_pos, req.payload.first_obj);
      tbl_wr_addr = tbl_idx[TBL_AW-1:0];
      tbl_wr_data = req.payload.domain_code;
    end else if (state == ST_LOOK) begin
      tbl_idx     = table_index(lpos[k[1:0]], lobj[k[1:0]]);
      look_ok     = table_hit(lpos[k[1:0]], lobj[k[1:0]]);
      tbl_rd_en   = (k < n) && look_ok;
      tbl_rd_addr = tbl_idx[TBL_AW-1:0];
    end
  end

  // bitmap port: sweep clear, row read for a rank, read-modify-write
  always_comb begin
    bm_wr_en   = 1'b0;
    bm_wr_addr = '0;
    bm_wr_data = '0;
    bm_rd_en   = 1'b0;
    bm_rd_addr = rank_ext[ROW_SEL_W +: ROW_AW];
    if (state == ST_SWEEP) begin
      bm_wr_en   = (sweep_ext < 32'(ROWS));
      bm_wr_addr = sweep_ext[ROW_AW-1:0];
    end else if (state == ST_RANK) begin
      bm_rd_en = in_range;
    end else if (state == ST_WRITE && !is_query) begin
      bm_wr_en   = inr_r;
      bm_wr_addr = rank_r_ext[ROW_SEL_W +: ROW_AW];
      bm_wr_data = bm_rd_data | (ROW_BITS'(1) << rank_r[ROW_SEL_W-1:0]);
    end
  end

  aps_ram #(
    .WIDTH (CODE_W),
    .DEPTH (TBL_DEPTH),
    .AW    (TBL_AW)
  ) u_code_table (
    .clk     (clk),
    .wr_en   (tbl_wr_en),
    .wr_addr (tbl_wr_addr),
    .wr_data (tbl_wr_data),
    .rd_en   (tbl_rd_en),
    .rd_addr (tbl_rd_addr),
    .rd_data (tbl_rd_data)
  );

  aps_ram #(
    .WIDTH (ROW_BITS),
    .DEPTH (ROWS),
    .AW    (ROW_AW)
  ) u_bitmap (
    .clk     (clk),
    .wr_en   (bm_wr_en),
    .wr_addr (bm_wr_addr),
    .wr_data (bm_wr_data),
    .rd_en   (bm_rd_en),
    .rd_addr (bm_rd_addr),
    .rd_data (bm_rd_data)
  );

  aps_rank_unit #(
    .SET_BITS (SET_BITS)
  ) u_rank (
    .slot_a     (slots[a]),
    .slot_b     (slots[b]),
    .is_edge    (a != b),
    .slot_count (slot_count),
    .rank       (rank),
    .in_range   (in_range)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      offset[0]  <= 7'd1;
      offset[1]  <= 7'd2;
      offset[2]  <= 7'd3;
      offset[3]  <= 7'd4;
      slot_count <= 7'd5;
    end else if (cfg_wr_en) begin
      if (cfg_index == REG_OFFSET0 || cfg_index == REG_OFFSET1 ||
          cfg_index == REG_OFFSET2 || cfg_index == REG_OFFSET3) begin
        offset[cfg_index[1:0]] <= cfg_data;
      end else if (cfg_index == REG_SLOT_COUNT) begin
        slot_count <= cfg_data;
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_SWEEP;
      sweep_cnt   <= '0;
      sweep_table <= 1'b1;
      sweep_reply <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      // in ST_FINISH the output register is reloaded below instead
      if (rsp_valid && rsp.ready && state != ST_FINISH) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_SWEEP: begin
          if (sweep_ext == 32'(SWEEP_LEN - 1)) begin
            sweep_cnt <= '0;
            state     <= sweep_reply ? ST_FINISH : ST_IDLE;
          end else begin
            sweep_cnt <= sweep_cnt + 1'b1;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            res_hit  <= 1'b0;
            res_rank <= '0;
            k        <= '0;
            a        <= 2'd0;
            b        <= (req.payload.cmd == CMD_QEDGE) ? 2'd1 : 2'd0;
            is_query <= req_query;
            lpos[0]  <= req_query ? req.payload.first_pos : 2'd0;
            lpos[1]  <= req_query ? req.payload.second_pos : 2'd1;
            lpos[2]  <= 2'd2;
            lpos[3]  <= 2'd3;
            lobj[0]  <= req_query ? req.payload.first_obj : req.payload.arg_obj0;
            lobj[1]  <= req_query ? req.payload.second_obj : req.payload.arg_obj1;
            lobj[2]  <= req.payload.arg_obj2;
            lobj[3]  <= req.payload.arg_obj3;
            unique case (req.payload.cmd)
              CMD_INSERT: begin
                n     <= arity_eff;
                state <= (arity_eff == '0) ? ST_FINISH : ST_LOOK;
              end
              CMD_QVERTEX: begin
                n     <= 3'd1;
                state <= ST_LOOK;
              end
              CMD_QEDGE: begin
                n     <= 3'd2;
                state <= ST_LOOK;
              end
              CMD_CLEAR: begin
                sweep_table <= 1'b0;
                sweep_reply <= 1'b1;
                sweep_cnt   <= '0;
                state       <= ST_SWEEP;
              end
              default: begin
                state <= ST_FINISH;
              end
            endcase
          end
        end
        ST_LOOK: begin
          // read for entry k goes out while entry k-1's code comes back
          if (k != '0) begin
            slots[km1[1:0]] <= {1'b0, offset[prev_pos]} +
                               (prev_ok ? SLOT_W'(tbl_rd_data) : '0);
          end
          prev_pos <= lpos[k[1:0]];
          prev_ok  <= look_ok;
          k        <= k + 3'd1;
          if (k == n) begin
            state <= ST_RANK;
          end
        end
        ST_RANK: begin
          rank_r <= rank;
          inr_r  <= in_range;
          state  <= ST_WRITE;
        end
        ST_WRITE: begin
          if (is_query) begin
            res_hit  <= inr_r && bm_rd_data[rank_r[ROW_SEL_W-1:0]];
            res_rank <= rank_r[OUT_RANK_W-1:0];
            state    <= ST_FINISH;
          end else if (b_inc < n) begin
            b     <= b + 2'd1;
            state <= ST_RANK;
          end else if (a_inc < n) begin
            a     <= a + 2'd1;
            b     <= a + 2'd1;
            state <= ST_RANK;
          end else begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid          <= 1'b1;
            rsp_data.hit       <= res_hit;
            rsp_data.slot_rank <= res_rank;
            sweep_reply        <= 1'b0;
            state              <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> tb/tb_assignment_pair_bitset.sv
module tb_assignment_pair_bitset;
  timeunit 1ns;
  timeprecision 1ps;
  import aps_pkg::*;

  localparam int TABLE_SIZE     = 64;
  localparam int MAP_BITS       = 8192;
  localparam int HOLD_CYCLES    = 250;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int MAX_REPORTS    = 10;
  localparam int RECENT_DEPTH   = 12;

  // cmd codes the block leaves unused
  localparam logic [CMD_W-1:0] CMD_RSVD5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

  logic clk = 1'b0;
  logic rst;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  aps_stream_if #(.T(req_t)) req ();
  aps_stream_if #(.T(rsp_t)) rsp ();

  assignment_pair_bitset u_dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow state of the block
  logic [CODE_W-1:0] code_mem [TABLE_SIZE];
  logic [MAP_BITS-1:0] member_map;
  logic [OFS_W-1:0] ofs [NUM_POS];
  logic [OFS_W-1:0] n_slots;

  rsp_t due_answers [$];
  rsp_t want;
  req_t recent_atoms [$];

  bit no_idle      = 1'b0;
  logic hold_pending = 1'b0;
  int hold_left    = 0;
  int holds_done   = 0;
  int errors       = 0;
  int req_beats    = 0;
  int rsp_beats    = 0;
  int hit_count    = 0;
  int clear_count  = 0;
  int dropped_q    = 0;
  int cfg_sets     = 0;
  int idle_cycles  = 0;

  function automatic logic [5:0] tbl_at(int unsigned pos, int unsigned obj);
    int unsigned idx;
    idx = pos * 16 + obj;
    return idx[5:0];
  endfunction

  function automatic int unsigned slot_of(int unsigned pos, int unsigned obj);
    return 32'(ofs[pos[1:0]]) + 32'(code_mem[tbl_at(pos, obj)]);
  endfunction

  function automatic void mark_rank(int unsigned rank);
    if (rank < MAP_BITS) member_map[rank[12:0]] = 1'b1;
  endfunction

  function automatic logic probe_rank(int unsigned rank);
    if (rank < MAP_BITS) return member_map[rank[12:0]];
    dropped_q++;
    return 1'b0;
  endfunction

  function automatic int unsigned sat_arity(req_t a);
    return (a.arity > ARG_FIELDS) ? ARG_FIELDS : 32'(a.arity);
  endfunction

  function automatic int unsigned atom_obj(req_t a, int unsigned pos);
    case (pos)
      0: return 32'(a.arg_obj0);
      1: return 32'(a.arg_obj1);
      2: return 32'(a.arg_obj2);
      default: return 32'(a.arg_obj3);
    endcase
  endfunction

  // expected answer for one command, updating the shadow bitmap and table
  function automatic rsp_t bitmap_answer(req_t r);
    rsp_t ans;
    int unsigned rank;
    int unsigned n_args;
    ans = '0;
    rank = 0;
    case (r.cmd)
      CMD_LOAD: code_mem[tbl_at(32'(r.first_pos), 32'(r.first_obj))] = r.domain_code;
      CMD_INSERT: begin
        n_args = sat_arity(r);
        for (int i = 0; i < n_args; i++) begin
          mark_rank(slot_of(i, atom_obj(r, i)));
          for (int j = i + 1; j < n_args; j++)
            mark_rank(slot_of(i, atom_obj(r, i)) * 32'(n_slots)
                      + slot_of(j, atom_obj(r, j)));
        end
      end
      CMD_QVERTEX: begin
        rank = slot_of(32'(r.first_pos), 32'(r.first_obj));
        ans.hit = probe_rank(rank);
        ans.slot_rank = rank[OUT_RANK_W-1:0];
      end
      CMD_QEDGE: begin
        rank = slot_of(32'(r.first_pos), 32'(r.first_obj)) * 32'(n_slots)
             + slot_of(32'(r.second_pos), 32'(r.second_obj));
        ans.hit = probe_rank(rank);
        ans.slot_rank = rank[OUT_RANK_W-1:0];
      end
      CMD_CLEAR: begin
        member_map = '0;
        clear_count++;
      end
      default: ;
    endcase
    return ans;
  endfunction

  // scoreboard and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp.valid && rsp.ready) begin
        rsp_beats++;
        if (due_answers.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: result beat with nothing expected: hit=%0b rank=%0d",
                     $realtime, rsp.payload.hit, rsp.payload.slot_rank);
        end else begin
          want = due_answers.pop_front();
          if (want.hit) hit_count++;
          if (rsp.payload.hit !== want.hit || rsp.payload.slot_rank !== want.slot_rank) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: mismatch: hit exp %0b got %0b, rank exp %0d got %0d",
                       $realtime, want.hit, rsp.payload.hit,
                       want.slot_rank, rsp.payload.slot_rank);
          end
        end
      end
      if (req.valid && req.ready) begin
        req_beats++;
        due_answers.push_back(bitmap_answer(req.payload));
      end
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("%0t: no beat for %0d cycles, %0d results outstanding",
                   $realtime, idle_cycles, due_answers.size());
          $display("[assignment_pair_bitset] ERROR");
          $finish;
        end
      end
    end
  end

  // result side: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      rsp.ready <= 1'b0;
    end else if (hold_pending) begin
      hold_left = HOLD_CYCLES;
      holds_done++;
      hold_pending <= 1'b0;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= no_idle || ($urandom_range(99) >= 11);
    end
  end

  function automatic req_t random_fill();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    return raw[$bits(req_t)-1:0];
  endfunction

  function automatic req_t mk_load(int unsigned pos, int unsigned obj, int unsigned code);
    req_t r;
    r = random_fill();
    r.cmd = CMD_LOAD;
    r.first_pos = POS_W'(pos);
    r.first_obj = OBJ_W'(obj);
    r.domain_code = CODE_W'(code);
    return r;
  endfunction

  function automatic req_t mk_insert(int unsigned arity, int unsigned o0, int unsigned o1,
                                     int unsigned o2, int unsigned o3);
    req_t r;
    r = random_fill();
    r.cmd = CMD_INSERT;
    r.arity = ARITY_W'(arity);
    r.arg_obj0 = OBJ_W'(o0);
    r.arg_obj1 = OBJ_W'(o1);
    r.arg_obj2 = OBJ_W'(o2);
    r.arg_obj3 = OBJ_W'(o3);
    return r;
  endfunction

  function automatic req_t mk_vertex(int unsigned pos, int unsigned obj);
    req_t r;
    r = random_fill();
    r.cmd = CMD_QVERTEX;
    r.first_pos = POS_W'(pos);
    r.first_obj = OBJ_W'(obj);
    return r;
  endfunction

  function automatic req_t mk_edge(int unsigned p1, int unsigned o1, int unsigned p2,
                                   int unsigned o2);
    req_t r;
    r = random_fill();
    r.cmd = CMD_QEDGE;
    r.first_pos = POS_W'(p1);
    r.first_obj = OBJ_W'(o1);
    r.second_pos = POS_W'(p2);
    r.second_obj = OBJ_W'(o2);
    return r;
  endfunction

  function automatic req_t mk_plain(logic [CMD_W-1:0] cmd);
    req_t r;
    r = random_fill();
    r.cmd = cmd;
    return r;
  endfunction

  // called at a falling edge; returns at the falling edge after the beat
  task automatic send_item(input req_t item);
    while (!no_idle && $urandom_range(99) < 11) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid <= 1'b1;
    req.payload <= item;
    do @(posedge clk); while (!req.ready);
    @(negedge clk);
  endtask

  task automatic wait_drain();
    req.valid <= 1'b0;
    @(negedge clk);
    while (due_answers.size() != 0) @(negedge clk);
  endtask

  task automatic program_regs(input logic [OFS_W-1:0] o0, input logic [OFS_W-1:0] o1,
                              input logic [OFS_W-1:0] o2, input logic [OFS_W-1:0] o3,
                              input logic [OFS_W-1:0] n);
    logic [CFG_DATA_W-1:0] vals [5];
    logic [CFG_IDX_W-1:0]  regs [5];
    vals = '{o0, o1, o2, o3, n};
    regs = '{REG_OFFSET0, REG_OFFSET1, REG_OFFSET2, REG_OFFSET3, REG_SLOT_COUNT};
    wait_drain();
    for (int i = 0; i < 5; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= regs[i[2:0]];
      cfg_data  <= vals[i[2:0]];
      @(negedge clk);
    end
    cfg_wr_en <= 1'b0;
    ofs = '{o0, o1, o2, o3};
    n_slots = n;
    cfg_sets++;
  endtask

  function automatic int unsigned rand_code();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 70) return $urandom_range(16, 1);
    if (p < 85) return 0;
    return $urandom_range(31, 17);
  endfunction

  // random mix biased toward queries of atoms inserted a little earlier
  task automatic run_phase(input int count);
    int unsigned p, s, i, j;
    req_t r, a;
    repeat (12) send_item(mk_load($urandom_range(3), $urandom_range(15), rand_code()));
    repeat (count) begin
      p = $urandom_range(99);
      if (recent_atoms.size() != 0)
        a = recent_atoms[$urandom_range(recent_atoms.size() - 1)];
      else
        a = mk_insert(0, 0, 0, 0, 0);
      s = sat_arity(a);
      if (p < 8) begin
        r = mk_load($urandom_range(3), $urandom_range(15), rand_code());
      end else if (p < 38 || p >= 97) begin
        r = mk_insert((p < 38 && $urandom_range(99) < 85) ? $urandom_range(4, 1)
                                                          : $urandom_range(7),
                      $urandom_range(15), $urandom_range(15),
                      $urandom_range(15), $urandom_range(15));
        recent_atoms.push_back(r);
        if (recent_atoms.size() > RECENT_DEPTH) void'(recent_atoms.pop_front());
      end else if (p < 62) begin
        if (s >= 1 && $urandom_range(99) < 60) begin
          i = $urandom_range(s - 1);
          r = mk_vertex(i, atom_obj(a, i));
        end else begin
          r = mk_vertex($urandom_range(3), $urandom_range(15));
        end
      end else if (p < 94) begin
        if (s >= 2 && $urandom_range(99) < 60) begin
          i = $urandom_range(s - 2);
          j = $urandom_range(s - 1, i + 1);
          r = mk_edge(i, atom_obj(a, i), j, atom_obj(a, j));
        end else begin
          r = mk_edge($urandom_range(3), $urandom_range(15),
                      $urandom_range(3), $urandom_range(15));
        end
      end else if (p < 96) begin
        case ($urandom_range(2))
          0: r = mk_plain(CMD_RSVD5);
          1: r = mk_plain(CMD_RSVD6);
          default: r = mk_plain(CMD_RSVD7);
        endcase
      end else begin
        r = mk_plain(CMD_CLEAR);
      end
      send_item(r);
    end
  endtask

  task automatic test_directed_basics();
    program_regs(7'd1, 7'd20, 7'd40, 7'd60, 7'd69);
    send_item(mk_load(0, 0, 1));
    send_item(mk_load(3, 15, 16));
    send_item(mk_load(1, 15, 31));
    send_item(mk_load(2, 0, 0));          // outside the domain: bare offset
    send_item(mk_insert(4, 0, 15, 0, 15));
    send_item(mk_vertex(0, 0));
    send_item(mk_vertex(3, 15));
    send_item(mk_edge(0, 0, 3, 15));
    send_item(mk_edge(3, 15, 0, 0));
    send_item(mk_insert(0, 15, 15, 15, 15));
    send_item(mk_insert(7, 15, 15, 15, 15)); // arity saturates at four
    send_item(mk_insert(1, 7, 0, 0, 0));
    send_item(mk_vertex(2, 7));
    send_item('1);                         // every field at its top value
    send_item(mk_plain(CMD_RSVD5));
    send_item(mk_plain(CMD_RSVD6));
    send_item(mk_plain(CMD_CLEAR));
    send_item(mk_vertex(0, 0));
    send_item(mk_edge(0, 0, 1, 15));
  endtask

  task automatic test_rank_beyond_store();
    program_regs(7'd127, 7'd127, 7'd127, 7'd127, 7'd127);
    send_item(mk_load(0, 3, 31));
    send_item(mk_insert(2, 3, 15, 0, 0)); // edge rank lands past the bitmap
    send_item(mk_edge(0, 3, 1, 15));
    send_item(mk_vertex(0, 3));
  endtask

  task automatic test_config_sweep();
    program_regs(7'd1, 7'd1, 7'd1, 7'd1, 7'd1);
    run_phase(200);
    program_regs(7'd68, 7'd68, 7'd68, 7'd68, 7'd69);
    run_phase(200);
    program_regs(7'd0, 7'd0, 7'd0, 7'd0, 7'd0);
    run_phase(150);
    program_regs(7'd127, 7'd127, 7'd127, 7'd127, 7'd127);
    run_phase(150);
    repeat (3) begin
      program_regs(OFS_W'($urandom_range(68, 1)), OFS_W'($urandom_range(68, 1)),
                   OFS_W'($urandom_range(68, 1)), OFS_W'($urandom_range(68, 1)),
                   OFS_W'($urandom_range(69, 1)));
      run_phase(200);
    end
  endtask

  task automatic test_no_idle_stretch();
    program_regs(7'd1, 7'd2, 7'd3, 7'd4, 7'd5);
    no_idle <= 1'b1;
    run_phase(250);
    wait_drain();
    no_idle <= 1'b0;
  endtask

  // result side holds off while beats keep coming until the input stalls
  task automatic test_backpressure();
    wait_drain();
    hold_pending <= 1'b1;
    no_idle <= 1'b1;
    run_phase(12);
    no_idle <= 1'b0;
    wait_drain();
  endtask

  initial begin
    rst = 1'b1;
    req.valid = 1'b0;
    req.payload = '0;
    rsp.ready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    foreach (code_mem[k]) code_mem[k] = '0;
    member_map = '0;
    ofs = '{7'd1, 7'd2, 7'd3, 7'd4};
    n_slots = 7'd5;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    test_directed_basics();
    test_rank_beyond_store();
    test_config_sweep();
    test_no_idle_stretch();
    test_backpressure();

    wait_drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (due_answers.size() != 0) begin
      errors++;
      $display("%0d results never arrived", due_answers.size());
    end
    $display("%0d commands, %0d results, %0d hits, %0d clears, %0d queries past the bitmap",
             req_beats, rsp_beats, hit_count, clear_count, dropped_q);
    $display("%0d register settings, %0d long result hold-offs, %0d failures",
             cfg_sets, holds_done, errors);
    if (errors == 0) begin
      $display("[assignment_pair_bitset] OK");
    end else begin
      $display("[assignment_pair_bitset] ERROR");
    end
    $finish;
  end

endmodule
